@@ sv/tbt_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tbt_pkg
// shared constants and codes for the triangle backface test core
// ----------------------------------------------------------------------------
package tbt_pkg;

  localparam int unsigned COORD_BITS_DEF = 16;
  localparam int unsigned FLAG_BITS      = 5;
  localparam int unsigned CFG_IDX_BITS   = 2;

  // tri_flags bit positions
  localparam int unsigned FLAG_ACTIVE    = 0;
  localparam int unsigned FLAG_CLIPPED   = 1;
  localparam int unsigned FLAG_BACKFACE  = 2;
  localparam int unsigned FLAG_TWO_SIDED = 3;
  localparam int unsigned FLAG_CULLED    = 4;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_CAM_X = 2'd0,
    REG_CAM_Y = 2'd1,
    REG_CAM_Z = 2'd2
  } tbt_reg_e;

endpackage : tbt_pkg
`default_nettype wire

@@ sv/tbt_tri_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tbt_tri_if
// triangle input channel: three vertices and status flags
// ----------------------------------------------------------------------------
interface tbt_tri_if #(
  parameter int unsigned COORD_BITS = tbt_pkg::COORD_BITS_DEF
);
  import tbt_pkg::*;

  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] v0_x;
  logic signed [COORD_BITS-1:0] v0_y;
  logic signed [COORD_BITS-1:0] v0_z;
  logic signed [COORD_BITS-1:0] v1_x;
  logic signed [COORD_BITS-1:0] v1_y;
  logic signed [COORD_BITS-1:0] v1_z;
  logic signed [COORD_BITS-1:0] v2_x;
  logic signed [COORD_BITS-1:0] v2_y;
  logic signed [COORD_BITS-1:0] v2_z;
  logic [FLAG_BITS-1:0]         tri_flags;

  modport source (
    output valid, v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z, tri_flags,
    input  ready
  );

  modport sink (
    input  valid, v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z, tri_flags,
    output ready
  );

endinterface : tbt_tri_if
`default_nettype wire

@@ sv/tbt_res_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tbt_res_if
// result channel: backface status and tested flag
// ----------------------------------------------------------------------------
interface tbt_res_if;

  logic valid;
  logic ready;
  logic is_backface;
  logic was_tested;

  modport source (
    output valid, is_backface, was_tested,
    input  ready
  );

  modport sink (
    input  valid, is_backface, was_tested,
    output ready
  );

endinterface : tbt_res_if
`default_nettype wire

@@ sv/triangle_backface_test_core.sv @@
`default_nettype none
// Throughput: one triangle per cycle; each of the five register stages holds
// its own valid bit, so a stall at the output fills bubbles before it blocks.
// The widest multipliers sit in stage 4 (normal times view vector).
// Reset clears all stage valid bits and sets the camera position to the origin.
// ----------------------------------------------------------------------------
// triangle_backface_test_core
// cross product normal, view vector dot product and sign test in a pipeline
// ----------------------------------------------------------------------------
module triangle_backface_test_core #(
  parameter int unsigned COORD_BITS = tbt_pkg::COORD_BITS_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  tbt_tri_if.sink                              tri_i,
  tbt_res_if.source                            res_o,
  input  wire logic                            cfg_we_i,
  input  wire logic [tbt_pkg::CFG_IDX_BITS-1:0] cfg_idx_i,
  input  wire logic [COORD_BITS-1:0]           cfg_data_i
);
  import tbt_pkg::*;

  localparam int unsigned DW = COORD_BITS + 1;  // vertex difference
  localparam int unsigned PW = 2 * DW;          // difference product
  localparam int unsigned NW = PW + 1;          // normal component
  localparam int unsigned QW = NW + DW;         // normal times view
  localparam int unsigned SW = QW + 2;          // dot product
  localparam int unsigned NST = 5;

  // camera registers
  logic signed [COORD_BITS-1:0] cam_x_q, cam_y_q, cam_z_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cam_x_q <= '0;
      cam_y_q <= '0;
      cam_z_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_CAM_X: cam_x_q <= cfg_data_i;
        REG_CAM_Y: cam_y_q <= cfg_data_i;
        REG_CAM_Z: cam_z_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // stage handshake
  logic [NST-1:0] vld_q, vld_d;
  logic [NST-1:0] rdy;
  logic [NST-1:0] tst_q, tst_d;
  logic [NST-1:0] bk_q, bk_d;

  always_comb begin
    rdy[NST-1] = !vld_q[NST-1] || res_o.ready;
    for (int k = NST - 2; k >= 0; k--) begin
      rdy[k] = !vld_q[k] || rdy[k+1];
    end
  end

  assign tri_i.ready = rdy[0];

  logic tested_in;
  assign tested_in = tri_i.tri_flags[FLAG_ACTIVE] && !tri_i.tri_flags[FLAG_CLIPPED] &&
                     !tri_i.tri_flags[FLAG_BACKFACE] && !tri_i.tri_flags[FLAG_TWO_SIDED] &&
                     !tri_i.tri_flags[FLAG_CULLED];

  always_comb begin
    vld_d = vld_q;
    tst_d = tst_q;
    bk_d  = bk_q;
    if (rdy[0]) begin
      vld_d[0] = tri_i.valid;
      tst_d[0] = tested_in;
      bk_d[0]  = tri_i.tri_flags[FLAG_BACKFACE];
    end
    for (int k = 1; k < NST; k++) begin
      if (rdy[k]) begin
        vld_d[k] = vld_q[k-1];
        tst_d[k] = tst_q[k-1];
        bk_d[k]  = bk_q[k-1];
      end
    end
  end

  // stage 1: edge and view vectors
  logic signed [DW-1:0] ux_d, uy_d, uz_d, vx_d, vy_d, vz_d, wx_d, wy_d, wz_d;
  logic signed [DW-1:0] s1_ux_q, s1_uy_q, s1_uz_q, s1_vx_q, s1_vy_q, s1_vz_q;
  logic signed [DW-1:0] s1_wx_q, s1_wy_q, s1_wz_q;

  always_comb begin
    ux_d = {tri_i.v1_x[COORD_BITS-1], tri_i.v1_x} - {tri_i.v0_x[COORD_BITS-1], tri_i.v0_x};
    uy_d = {tri_i.v1_y[COORD_BITS-1], tri_i.v1_y} - {tri_i.v0_y[COORD_BITS-1], tri_i.v0_y};
    uz_d = {tri_i.v1_z[COORD_BITS-1], tri_i.v1_z} - {tri_i.v0_z[COORD_BITS-1], tri_i.v0_z};
    vx_d = {tri_i.v2_x[COORD_BITS-1], tri_i.v2_x} - {tri_i.v0_x[COORD_BITS-1], tri_i.v0_x};
    vy_d = {tri_i.v2_y[COORD_BITS-1], tri_i.v2_y} - {tri_i.v0_y[COORD_BITS-1], tri_i.v0_y};
    vz_d = {tri_i.v2_z[COORD_BITS-1], tri_i.v2_z} - {tri_i.v0_z[COORD_BITS-1], tri_i.v0_z};
    wx_d = {cam_x_q[COORD_BITS-1], cam_x_q} - {tri_i.v0_x[COORD_BITS-1], tri_i.v0_x};
    wy_d = {cam_y_q[COORD_BITS-1], cam_y_q} - {tri_i.v0_y[COORD_BITS-1], tri_i.v0_y};
    wz_d = {cam_z_q[COORD_BITS-1], cam_z_q} - {tri_i.v0_z[COORD_BITS-1], tri_i.v0_z};
  end

  // stage 2: cross product partial products
  logic signed [PW-1:0] s2_p0_q, s2_p1_q, s2_p2_q, s2_p3_q, s2_p4_q, s2_p5_q;
  logic signed [DW-1:0] s2_wx_q, s2_wy_q, s2_wz_q;

  // stage 3: normal
  logic signed [NW-1:0] nx_d, ny_d, nz_d;
  logic signed [NW-1:0] s3_nx_q, s3_ny_q, s3_nz_q;
  logic signed [DW-1:0] s3_wx_q, s3_wy_q, s3_wz_q;

  always_comb begin
    nx_d = {s2_p0_q[PW-1], s2_p0_q} - {s2_p1_q[PW-1], s2_p1_q};
    ny_d = {s2_p2_q[PW-1], s2_p2_q} - {s2_p3_q[PW-1], s2_p3_q};
    nz_d = {s2_p4_q[PW-1], s2_p4_q} - {s2_p5_q[PW-1], s2_p5_q};
  end

  // stage 4: dot product terms
  logic signed [QW-1:0] s4_qx_q, s4_qy_q, s4_qz_q;

  // stage 5: sum and sign test
  logic signed [SW-1:0] dot;
  logic                 back_tst;
  logic                 res_bk_d;
  logic                 res_bk_q, res_tst_q;

  always_comb begin
    dot = {{2{s4_qx_q[QW-1]}}, s4_qx_q} + {{2{s4_qy_q[QW-1]}}, s4_qy_q} +
          {{2{s4_qz_q[QW-1]}}, s4_qz_q};
    back_tst = dot[SW-1] || (dot == '0);
    res_bk_d = tst_q[NST-2] ? back_tst : bk_q[NST-2];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
      tst_q <= '0;
      bk_q  <= '0;
    end else begin
      vld_q <= vld_d;
      tst_q <= tst_d;
      bk_q  <= bk_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      s1_ux_q <= ux_d;
      s1_uy_q <= uy_d;
      s1_uz_q <= uz_d;
      s1_vx_q <= vx_d;
      s1_vy_q <= vy_d;
      s1_vz_q <= vz_d;
      s1_wx_q <= wx_d;
      s1_wy_q <= wy_d;
      s1_wz_q <= wz_d;
    end
    if (rdy[1]) begin
      s2_p0_q <= PW'(s1_uy_q) * PW'(s1_vz_q);
      s2_p1_q <= PW'(s1_uz_q) * PW'(s1_vy_q);
      s2_p2_q <= PW'(s1_uz_q) * PW'(s1_vx_q);
      s2_p3_q <= PW'(s1_ux_q) * PW'(s1_vz_q);
      s2_p4_q <= PW'(s1_ux_q) * PW'(s1_vy_q);
      s2_p5_q <= PW'(s1_uy_q) * PW'(s1_vx_q);
      s2_wx_q <= s1_wx_q;
      s2_wy_q <= s1_wy_q;
      s2_wz_q <= s1_wz_q;
    end
    if (rdy[2]) begin
      s3_nx_q <= nx_d;
      s3_ny_q <= ny_d;
      s3_nz_q <= nz_d;
      s3_wx_q <= s2_wx_q;
      s3_wy_q <= s2_wy_q;
      s3_wz_q <= s2_wz_q;
    end
    if (rdy[3]) begin
      s4_qx_q <= QW'(s3_nx_q) * QW'(s3_wx_q);
      s4_qy_q <= QW'(s3_ny_q) * QW'(s3_wy_q);
      s4_qz_q <= QW'(s3_nz_q) * QW'(s3_wz_q);
    end
    if (rdy[4]) begin
      res_bk_q  <= res_bk_d;
      res_tst_q <= tst_q[NST-2];
    end
  end

  assign res_o.valid       = vld_q[NST-1];
  assign res_o.is_backface = res_bk_q;
  assign res_o.was_tested  = res_tst_q;

`ifndef SYNTHESIS
  a_accept_fills_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tri_i.valid && tri_i.ready |=> vld_q[0])
    else $error("accepted beat did not reach stage 1");

  a_s1_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[0] && !rdy[1] |=> vld_q[0] && $stable(s1_ux_q) && $stable(s1_wz_q))
    else $error("stalled stage 1 lost its payload");

  a_s4_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[NST-2] && rdy[NST-1] |=> res_o.valid)
    else $error("stage 4 beat dropped before output");

  a_stall_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !tri_i.ready |-> res_o.valid && !res_o.ready && ($countones(vld_q) == NST))
    else $error("input stalled while the pipeline had room");

  a_untested_keeps_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[NST-2] && rdy[NST-1] && !tst_q[NST-2] |=> res_o.is_backface == $past(bk_q[NST-2]))
    else $error("untested triangle changed its backface bit");
`endif

endmodule : triangle_backface_test_core
`default_nettype wire

@@ tb/tbt_backface_checker.sv @@
// ----------------------------------------------------------------------------
// tbt_backface_checker
// Watches the triangle and result channels and the camera register port.
// For every accepted triangle beat it predicts the culling verdict from the
// cross product normal and the view vector at full width. It then checks each
// result beat, field by field, against the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module tbt_backface_checker #(
  parameter int unsigned COORD_BITS = tbt_pkg::COORD_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  tbt_tri_if                               tri_i,
  tbt_res_if                               res_i,
  input  logic                             cfg_we_i,
  input  logic [tbt_pkg::CFG_IDX_BITS-1:0] cfg_idx_i,
  input  logic [COORD_BITS-1:0]            cfg_data_i,
  output int                               mismatches_o,
  output int                               outstanding_o
);
  import tbt_pkg::*;

  localparam int unsigned WIDE_BITS = 4 * COORD_BITS + 8;
  localparam int          REPORT_MAX = 10;

  typedef logic signed [WIDE_BITS-1:0]  wide_t;
  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef struct packed {
    logic is_backface;
    logic was_tested;
  } verdict_t;

  coord_t   cam_x;
  coord_t   cam_y;
  coord_t   cam_z;
  verdict_t verdict_q[$];
  int       mismatches;
  int       outstanding;

  assign mismatches_o  = mismatches;
  assign outstanding_o = outstanding;

  function automatic verdict_t cull_verdict(
    coord_t p0x, coord_t p0y, coord_t p0z,
    coord_t p1x, coord_t p1y, coord_t p1z,
    coord_t p2x, coord_t p2y, coord_t p2z,
    logic [FLAG_BITS-1:0] flags
  );
    wide_t    ux, uy, uz, vx, vy, vz, wx, wy, wz, nx, ny, nz, dot;
    verdict_t v;
    v.was_tested  = flags[FLAG_ACTIVE] && !flags[FLAG_CLIPPED] && !flags[FLAG_BACKFACE] &&
                    !flags[FLAG_TWO_SIDED] && !flags[FLAG_CULLED];
    v.is_backface = flags[FLAG_BACKFACE];
    if (v.was_tested) begin
      ux  = wide_t'(p1x) - wide_t'(p0x);
      uy  = wide_t'(p1y) - wide_t'(p0y);
      uz  = wide_t'(p1z) - wide_t'(p0z);
      vx  = wide_t'(p2x) - wide_t'(p0x);
      vy  = wide_t'(p2y) - wide_t'(p0y);
      vz  = wide_t'(p2z) - wide_t'(p0z);
      wx  = wide_t'(cam_x) - wide_t'(p0x);
      wy  = wide_t'(cam_y) - wide_t'(p0y);
      wz  = wide_t'(cam_z) - wide_t'(p0z);
      nx  = uy * vz - uz * vy;
      ny  = uz * vx - ux * vz;
      nz  = ux * vy - uy * vx;
      dot = nx * wx + ny * wy + nz * wz;
      // grazing view and zero normal both count as backface
      v.is_backface = (dot <= 0);
    end
    return v;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    verdict_t want;
    verdict_t got;
    if (!rst_ni) begin
      cam_x       <= '0;
      cam_y       <= '0;
      cam_z       <= '0;
      mismatches  <= 0;
      outstanding <= 0;
      verdict_q.delete();
    end else begin
      if (res_i.valid && res_i.ready) begin
        got.is_backface = res_i.is_backface;
        got.was_tested  = res_i.was_tested;
        if (verdict_q.size() == 0) begin
          if (mismatches < REPORT_MAX) begin
            $display("[%0t] unexpected result beat: is_backface %b was_tested %b",
                     $realtime, got.is_backface, got.was_tested);
          end
          mismatches <= mismatches + 1;
        end else begin
          want = verdict_q.pop_front();
          if (want.is_backface !== got.is_backface || want.was_tested !== got.was_tested) begin
            if (mismatches < REPORT_MAX) begin
              $display("[%0t] result mismatch: is_backface exp %b got %b, was_tested exp %b got %b",
                       $realtime, want.is_backface, got.is_backface,
                       want.was_tested, got.was_tested);
            end
            mismatches <= mismatches + 1;
          end
        end
      end
      if (tri_i.valid && tri_i.ready) begin
        verdict_q.insert(verdict_q.size(),
                         cull_verdict(tri_i.v0_x, tri_i.v0_y, tri_i.v0_z,
                                      tri_i.v1_x, tri_i.v1_y, tri_i.v1_z,
                                      tri_i.v2_x, tri_i.v2_y, tri_i.v2_z,
                                      tri_i.tri_flags));
      end
      outstanding <= verdict_q.size();
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_CAM_X: cam_x <= cfg_data_i;
          REG_CAM_Y: cam_y <= cfg_data_i;
          REG_CAM_Z: cam_z <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

endmodule : tbt_backface_checker

@@ tb/triangle_backface_test_core_test.sv @@
// ----------------------------------------------------------------------------
// triangle_backface_test_core_test
// Drives triangles and camera settings into the backface test core. A short
// directed set covers the flag cases, the grazing view, degenerate triangles
// and extreme coordinates. Five phases of random triangles follow, each under
// its own camera position. Both channel sides stall at random, with one
// phase free of stalls. The checker beside the core does the comparison.
// ----------------------------------------------------------------------------
module triangle_backface_test_core_test;
  import tbt_pkg::*;

  localparam int unsigned COORD_BITS   = COORD_BITS_DEF;
  localparam int          RESET_CYCLES = 6;
  localparam int          SETTLE_CYCLES = 12;
  localparam int          CYCLE_LIMIT  = 200000;
  localparam int          PHASES       = 5;
  localparam int          PHASE_ITEMS  = 390;
  localparam int          CALM_PHASE   = 2;
  localparam int          IDLE_PCT     = 33;

  localparam logic [CFG_IDX_BITS-1:0] REG_SPARE = 2'd3;

  localparam logic [FLAG_BITS-1:0] M_ACTIVE    = FLAG_BITS'(1) << FLAG_ACTIVE;
  localparam logic [FLAG_BITS-1:0] M_CLIPPED   = FLAG_BITS'(1) << FLAG_CLIPPED;
  localparam logic [FLAG_BITS-1:0] M_BACKFACE  = FLAG_BITS'(1) << FLAG_BACKFACE;
  localparam logic [FLAG_BITS-1:0] M_TWO_SIDED = FLAG_BITS'(1) << FLAG_TWO_SIDED;
  localparam logic [FLAG_BITS-1:0] M_CULLED    = FLAG_BITS'(1) << FLAG_CULLED;
  localparam logic [FLAG_BITS-1:0] M_ALL       = '1;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  localparam coord_t C_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};
  localparam coord_t C_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};

  typedef struct packed {
    coord_t               v0_x, v0_y, v0_z;
    coord_t               v1_x, v1_y, v1_z;
    coord_t               v2_x, v2_y, v2_z;
    logic [FLAG_BITS-1:0] tri_flags;
  } tri_t;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    cfg_we;
  logic [CFG_IDX_BITS-1:0] cfg_idx;
  logic [COORD_BITS-1:0]   cfg_data;
  logic                    calm = 1'b0;
  int                      mismatches;
  int                      outstanding;
  int                      cycle_count = 0;

  tbt_tri_if #(.COORD_BITS(COORD_BITS)) tri_ch ();
  tbt_res_if res_ch ();

  triangle_backface_test_core #(.COORD_BITS(COORD_BITS)) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .tri_i      (tri_ch),
    .res_o      (res_ch),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  tbt_backface_checker #(.COORD_BITS(COORD_BITS)) checker_inst (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .tri_i         (tri_ch),
    .res_i         (res_ch),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_data_i    (cfg_data),
    .mismatches_o  (mismatches),
    .outstanding_o (outstanding)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("triangle_backface_test_core verification failed");
      $finish;
    end
  end

  // result side back-pressure
  always @(posedge clk_i) begin
    res_ch.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
  end

  function automatic tri_t make_tri(
    coord_t x0, coord_t y0, coord_t z0,
    coord_t x1, coord_t y1, coord_t z1,
    coord_t x2, coord_t y2, coord_t z2,
    logic [FLAG_BITS-1:0] flags
  );
    tri_t t;
    t = {x0, y0, z0, x1, y1, z1, x2, y2, z2, flags};
    return t;
  endfunction

  function automatic coord_t rand_coord();
    case ($urandom_range(9))
      0:       return C_MIN;
      1:       return C_MAX;
      2, 3, 4: return coord_t'(int'($urandom_range(512)) - 256);
      default: return coord_t'($urandom);
    endcase
  endfunction

  function automatic tri_t random_triangle();
    tri_t t;
    t.v0_x = rand_coord();
    t.v0_y = rand_coord();
    t.v0_z = rand_coord();
    t.v1_x = rand_coord();
    t.v1_y = rand_coord();
    t.v1_z = rand_coord();
    t.v2_x = rand_coord();
    t.v2_y = rand_coord();
    t.v2_z = rand_coord();
    // occasional collapsed edge
    if ($urandom_range(99) < 3) begin
      t.v1_x = t.v0_x;
      t.v1_y = t.v0_y;
      t.v1_z = t.v0_z;
    end
    t.tri_flags = ($urandom_range(99) < 70) ? M_ACTIVE : FLAG_BITS'($urandom_range(31));
    return t;
  endfunction

  task automatic send_triangle(input tri_t t);
    if (!calm) begin
      while ($urandom_range(99) < IDLE_PCT) begin
        tri_ch.valid <= 1'b0;
        @(posedge clk_i);
      end
    end
    tri_ch.valid     <= 1'b1;
    tri_ch.v0_x      <= t.v0_x;
    tri_ch.v0_y      <= t.v0_y;
    tri_ch.v0_z      <= t.v0_z;
    tri_ch.v1_x      <= t.v1_x;
    tri_ch.v1_y      <= t.v1_y;
    tri_ch.v1_z      <= t.v1_z;
    tri_ch.v2_x      <= t.v2_x;
    tri_ch.v2_y      <= t.v2_y;
    tri_ch.v2_z      <= t.v2_z;
    tri_ch.tri_flags <= t.tri_flags;
    do @(posedge clk_i); while (!tri_ch.ready);
  endtask

  task automatic drain_results();
    tri_ch.valid <= 1'b0;
    do @(posedge clk_i); while (outstanding != 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input coord_t data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_camera(input coord_t x, input coord_t y, input coord_t z);
    write_reg(REG_CAM_X, x);
    write_reg(REG_CAM_Y, y);
    write_reg(REG_CAM_Z, z);
  endtask

  initial begin
    tri_t front;
    tri_t back;
    tri_t side;
    front = make_tri(0, 0, -16, 16, 0, -16, 0, 16, -16, M_ACTIVE);
    back  = make_tri(0, 0, -16, 0, 16, -16, 16, 0, -16, M_ACTIVE);
    side  = make_tri(16, 0, 0, 16, 16, 0, 16, 0, 16, M_ACTIVE);

    tri_ch.valid     <= 1'b0;
    tri_ch.v0_x      <= '0;
    tri_ch.v0_y      <= '0;
    tri_ch.v0_z      <= '0;
    tri_ch.v1_x      <= '0;
    tri_ch.v1_y      <= '0;
    tri_ch.v1_z      <= '0;
    tri_ch.v2_x      <= '0;
    tri_ch.v2_y      <= '0;
    tri_ch.v2_z      <= '0;
    tri_ch.tri_flags <= '0;
    cfg_we           <= 1'b0;
    cfg_idx          <= REG_CAM_X;
    cfg_data         <= '0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // camera still at its reset position
    send_triangle(front);
    send_triangle(back);
    send_triangle(side);
    send_triangle(make_tri(16, 0, 0, 0, 16, 0, -16, 0, 0, M_ACTIVE));
    send_triangle(make_tri(100, 200, 300, 100, 200, 300, 100, 200, 300, M_ACTIVE));
    send_triangle(make_tri(0, 0, 0, 16, 16, 16, 32, 32, 32, M_ACTIVE));
    send_triangle(make_tri(C_MIN, C_MIN, C_MIN, C_MAX, C_MIN, C_MIN, C_MIN, C_MAX, C_MIN,
                           M_ACTIVE));
    send_triangle(make_tri(C_MIN, C_MIN, C_MIN, C_MIN, C_MAX, C_MIN, C_MAX, C_MIN, C_MIN,
                           M_ACTIVE));
    send_triangle(make_tri(C_MAX, C_MAX, C_MAX, C_MIN, C_MAX, C_MAX, C_MAX, C_MIN, C_MAX,
                           M_ACTIVE));
    send_triangle(make_tri(C_MIN, C_MAX, C_MIN, C_MAX, C_MIN, C_MAX, C_MAX, C_MAX, C_MIN,
                           M_ACTIVE));
    front.tri_flags = '0;
    send_triangle(front);
    front.tri_flags = M_BACKFACE;
    send_triangle(front);
    front.tri_flags = M_ACTIVE | M_CLIPPED;
    send_triangle(front);
    front.tri_flags = M_ACTIVE | M_BACKFACE;
    send_triangle(front);
    front.tri_flags = M_ACTIVE | M_TWO_SIDED;
    send_triangle(front);
    front.tri_flags = M_ACTIVE | M_CULLED;
    send_triangle(front);
    front.tri_flags = M_ALL;
    send_triangle(front);
    back.tri_flags = M_ACTIVE | M_TWO_SIDED;
    send_triangle(back);
    drain_results();

    // write to an unmapped index leaves the camera alone
    write_reg(REG_SPARE, C_MAX);
    send_triangle(side);
    drain_results();

    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        1:       set_camera(C_MAX, C_MAX, C_MAX);
        2:       set_camera(C_MIN, C_MIN, C_MIN);
        3:       set_camera(C_MAX, C_MIN, '0);
        default: set_camera(rand_coord(), rand_coord(), rand_coord());
      endcase
      calm = (phase == CALM_PHASE);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (i == PHASE_ITEMS / 2) begin
          drain_results();
        end
        send_triangle(random_triangle());
      end
      drain_results();
    end

    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && outstanding == 0) begin
      $display("triangle_backface_test_core verification clean");
    end else begin
      $display("triangle_backface_test_core verification failed");
    end
    $finish;
  end

endmodule : triangle_backface_test_core_test
